// File: rtl/point_box_distance_features_unit_macros.svh
`ifndef POINT_BOX_DISTANCE_FEATURES_UNIT_MACROS_SVH
`define POINT_BOX_DISTANCE_FEATURES_UNIT_MACROS_SVH

// clocked check, off during reset
`define PBD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pbd assertion failed");

// clocked check that a condition never holds
`define PBD_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("pbd forbidden condition seen");

`endif

// File: rtl/pbd_pkg.sv
package pbd_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned DistW  = 25;
  localparam int unsigned RadW   = 52;
  localparam int unsigned RootW  = RadW / 2;
  localparam int unsigned RemW   = RootW + 2;
  localparam int unsigned NumRegs = 6;
  localparam int unsigned IdxW   = 3;

  typedef enum logic [IdxW-1:0] {
    REG_MIN_X = 3'd0,
    REG_MAX_X = 3'd1,
    REG_MIN_Y = 3'd2,
    REG_MAX_Y = 3'd3,
    REG_MIN_Z = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [RadW-1:0]  rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } lane_t;

  typedef struct packed {
    lane_t            edge_l;
    lane_t            corner_l;
    logic [DistW-1:0] wall;
  } word_t;

  function automatic lane_t sqrt_step(lane_t l);
    logic [RemW-1:0] rem2;
    logic [RemW-1:0] trial;
    lane_t           r;
    rem2  = {l.rem[RemW-3:0], l.rad[RadW-1 -: 2]};
    trial = {l.root[RootW-1:0], 2'b01};
    r.rad = {l.rad[RadW-3:0], 2'b00};
    if (rem2 >= trial) begin
      r.rem  = rem2 - trial;
      r.root = {l.root[RootW-2:0], 1'b1};
    end else begin
      r.rem  = rem2;
      r.root = {l.root[RootW-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [CoordW-1:0] abs_diff(logic signed [CoordW-1:0] a,
                                                 logic signed [CoordW-1:0] b);
    logic signed [CoordW:0] d;
    d = {a[CoordW-1], a} - {b[CoordW-1], b};
    return d[CoordW] ? CoordW'(-d) : d[CoordW-1:0];
  endfunction

  function automatic logic [CoordW-1:0] span_dist(logic signed [CoordW-1:0] c,
                                                  logic signed [CoordW-1:0] a,
                                                  logic signed [CoordW-1:0] b);
    logic signed [CoordW-1:0] lo;
    logic signed [CoordW-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c < lo) begin
      return abs_diff(lo, c);
    end else if (c > hi) begin
      return abs_diff(c, hi);
    end
    return '0;
  endfunction

  function automatic logic [DistW-1:0] sat_root(logic [RootW-1:0] r);
    return (r[RootW-1:DistW] != '0) ? '1 : r[DistW-1:0];
  endfunction

endpackage

// File: rtl/point_box_distance_features_unit.sv
// channel | dir | handshake               | payload
// in      | in  | in_valid_i / in_ready_o   | point_x_i, point_y_i, point_z_i
// out     | out | out_valid_o / out_ready_i | wall_, edge_, corner_distance_o
// cfg     | in  | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One point per cycle unless the output stalls; three front stages (distances,
// squares, sums), then one cell per root bit of the 52-bit square-root chain.
// The last cell is the output register; the whole pipe holds while it is full
// and not taken, so in_ready_o follows out_ready_i when a word waits.
// Reset clears the box registers and all valid bits; cfg is always ready.
`include "point_box_distance_features_unit_macros.svh"

module point_box_distance_features_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [pbd_pkg::CoordW-1:0] point_x_i,
  input  logic signed [pbd_pkg::CoordW-1:0] point_y_i,
  input  logic signed [pbd_pkg::CoordW-1:0] point_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [pbd_pkg::DistW-1:0]         wall_distance_o,
  output logic [pbd_pkg::DistW-1:0]         edge_distance_o,
  output logic [pbd_pkg::DistW-1:0]         corner_distance_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pbd_pkg::IdxW-1:0]          cfg_index_i,
  input  logic [pbd_pkg::CoordW-1:0]        cfg_data_i
);
  import pbd_pkg::*;

  logic signed [CoordW-1:0] lo_q [3];
  logic signed [CoordW-1:0] hi_q [3];
  logic signed [CoordW-1:0] p [3];
  logic                     en;
  logic                     vld [RootW+1];
  word_t                    dat [RootW+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        lo_q[a] <= '0;
        hi_q[a] <= '0;
      end
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_MIN_X: lo_q[0] <= cfg_data_i;
        REG_MAX_X: hi_q[0] <= cfg_data_i;
        REG_MIN_Y: lo_q[1] <= cfg_data_i;
        REG_MAX_Y: hi_q[1] <= cfg_data_i;
        REG_MIN_Z: lo_q[2] <= cfg_data_i;
        REG_MAX_Z: hi_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign p[0] = point_x_i;
  assign p[1] = point_y_i;
  assign p[2] = point_z_i;

  assign en         = !vld[RootW] || out_ready_i;
  assign in_ready_o = en;

  pbd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i),
    .p_i    (p),
    .lo_i   (lo_q),
    .hi_i   (hi_q),
    .vld_o  (vld[0]),
    .dat_o  (dat[0])
  );

  for (genvar k = 0; k < RootW; k++) begin : g_cell
    pbd_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (vld[k]),
      .dat_i  (dat[k]),
      .vld_o  (vld[k+1]),
      .dat_o  (dat[k+1])
    );
  end

  assign out_valid_o       = vld[RootW];
  assign wall_distance_o   = dat[RootW].wall;
  assign edge_distance_o   = sat_root(dat[RootW].edge_l.root);
  assign corner_distance_o = sat_root(dat[RootW].corner_l.root);

  `PBD_ASSERT(a_wall_le_corner, out_valid_o |-> wall_distance_o <= corner_distance_o)
  `PBD_ASSERT(a_edge_le_corner, out_valid_o |-> edge_distance_o <= corner_distance_o)
  `PBD_NEVER(a_no_sat, out_valid_o && (corner_distance_o == '1))

endmodule

// File: rtl/pbd_front.sv
module pbd_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                vld_i,
  input  logic signed [pbd_pkg::CoordW-1:0]   p_i   [3],
  input  logic signed [pbd_pkg::CoordW-1:0]   lo_i  [3],
  input  logic signed [pbd_pkg::CoordW-1:0]   hi_i  [3],
  output logic                                vld_o,
  output pbd_pkg::word_t                      dat_o
);
  import pbd_pkg::*;

  logic              v1_q, v2_q, v3_q;
  logic [CoordW-1:0] w_q [3];
  logic [CoordW-1:0] s_q [3];
  logic [2*CoordW-1:0] wsq_q [3];
  logic [2*CoordW-1:0] ssq_q [3];
  logic [DistW-1:0]  wall2_q, wall3_q;
  logic [RadW-1:0]   edge_q, corner_q;

  logic [CoordW-1:0] w_d [3];
  logic [CoordW-1:0] s_d [3];
  logic [CoordW-1:0] wmin;
  logic [RadW-1:0]   cand [3];
  logic [RadW-1:0]   corner_d;
  logic [RadW-1:0]   edge_d;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      w_d[a] = (abs_diff(p_i[a], lo_i[a]) < abs_diff(p_i[a], hi_i[a])) ?
               abs_diff(p_i[a], lo_i[a]) : abs_diff(p_i[a], hi_i[a]);
      s_d[a] = span_dist(p_i[a], lo_i[a], hi_i[a]);
    end
  end

  always_comb begin
    wmin = (w_q[0] < w_q[1]) ? w_q[0] : w_q[1];
    wmin = (wmin < w_q[2]) ? wmin : w_q[2];
  end

  always_comb begin
    corner_d = RadW'(wsq_q[0]) + RadW'(wsq_q[1]) + RadW'(wsq_q[2]);
    cand[0]  = RadW'(ssq_q[0]) + RadW'(wsq_q[1]) + RadW'(wsq_q[2]);
    cand[1]  = RadW'(ssq_q[1]) + RadW'(wsq_q[2]) + RadW'(wsq_q[0]);
    cand[2]  = RadW'(ssq_q[2]) + RadW'(wsq_q[0]) + RadW'(wsq_q[1]);
    edge_d   = (cand[0] < cand[1]) ? cand[0] : cand[1];
    edge_d   = (edge_d < cand[2]) ? edge_d : cand[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < 3; a++) begin
        w_q[a]   <= w_d[a];
        s_q[a]   <= s_d[a];
        wsq_q[a] <= w_q[a] * w_q[a];
        ssq_q[a] <= s_q[a] * s_q[a];
      end
      wall2_q  <= DistW'(wmin);
      wall3_q  <= wall2_q;
      edge_q   <= edge_d;
      corner_q <= corner_d;
    end
  end

  assign vld_o = v3_q;
  always_comb begin
    dat_o.edge_l.rad    = edge_q;
    dat_o.edge_l.rem    = '0;
    dat_o.edge_l.root   = '0;
    dat_o.corner_l.rad  = corner_q;
    dat_o.corner_l.rem  = '0;
    dat_o.corner_l.root = '0;
    dat_o.wall          = wall3_q;
  end

endmodule

// File: rtl/pbd_sqrt_cell.sv
module pbd_sqrt_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  pbd_pkg::word_t dat_i,
  output logic           vld_o,
  output pbd_pkg::word_t dat_o
);
  import pbd_pkg::*;

  logic  vld_q;
  word_t dat_q, dat_d;

  always_comb begin
    dat_d.edge_l   = sqrt_step(dat_i.edge_l);
    dat_d.corner_l = sqrt_step(dat_i.corner_l);
    dat_d.wall     = dat_i.wall;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= dat_d;
    end
  end

  assign vld_o = vld_q;
  assign dat_o = dat_q;

endmodule
